// File: src/dflps_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the launch pitch solver.
// No dependencies.
package dflps_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ATAN_LEN              = 24;
  localparam logic [15:0] GRAVITY_RESET = 16'd2511;

  localparam int RAD_W      = 72;
  localparam int ROOT_W     = 36;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 4;

  localparam logic [1:0] ST_SOLVED  = 2'd0;
  localparam logic [1:0] ST_UNREACH = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;

  localparam logic REG_GRAVITY = 1'b0;

  typedef struct packed {
    logic [15:0]        d;
    logic [31:0]        v2;
    logic signed [53:0] yq;
    logic [1:0]         status;
  } side_t;

  // atan(2^-i) scaled 2^30 rad
  function automatic logic signed [31:0] atan_entry(input int unsigned i);
    logic signed [31:0] r;
    case (i)
      0:  r = 32'sd843314857;
      1:  r = 32'sd497837829;
      2:  r = 32'sd263043837;
      3:  r = 32'sd133525159;
      4:  r = 32'sd67021687;
      5:  r = 32'sd33543516;
      6:  r = 32'sd16775851;
      7:  r = 32'sd8388437;
      8:  r = 32'sd4194283;
      9:  r = 32'sd2097149;
      10: r = 32'sd1048576;
      11: r = 32'sd524288;
      12: r = 32'sd262144;
      13: r = 32'sd131072;
      14: r = 32'sd65536;
      15: r = 32'sd32768;
      16: r = 32'sd16384;
      17: r = 32'sd8192;
      18: r = 32'sd4096;
      19: r = 32'sd2048;
      20: r = 32'sd1024;
      21: r = 32'sd512;
      22: r = 32'sd256;
      23: r = 32'sd128;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/dflps_front.sv
// Front end: products, discriminant and numerator over six register stages.
// Depends on dflps_pkg.
module dflps_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [15:0]          v,
  input  logic [15:0]          d,
  input  logic signed [15:0]   h,
  input  logic [15:0]          g,
  output logic                 out_valid,
  output logic [dflps_pkg::RAD_W-1:0] radicand,
  output dflps_pkg::side_t     side
);

  logic [5:0] vld;

  logic [15:0]        s1_v, s1_d, s1_g;
  logic signed [15:0] s1_h;
  logic               s1_zero;

  logic [31:0]        s2_v2, s2_gd, s2_dd;
  logic signed [32:0] s2_gh;
  logic [15:0]        s2_d, s2_g;
  logic signed [15:0] s2_h;
  logic               s2_zero;

  logic signed [38:0] s3_p;
  logic [63:0]        s3_gg;
  logic [47:0]        s3_gdd;
  logic signed [48:0] s3_hv2;
  logic [31:0]        s3_v2;
  logic [15:0]        s3_d;
  logic               s3_zero;

  logic               s4_pneg;
  logic [63:0]        s4_lhs_lo;
  logic [37:0]        s4_lhs_hi;
  logic [71:0]        s4_rhs;
  logic signed [53:0] s4_yq;
  logic [31:0]        s4_v2;
  logic [15:0]        s4_d;
  logic               s4_zero;

  logic               s5_pneg;
  logic [71:0]        s5_lhs, s5_rhs;
  logic signed [53:0] s5_yq;
  logic [31:0]        s5_v2;
  logic [15:0]        s5_d;
  logic               s5_zero;

  logic [72:0]        diff;

  assign diff = {1'b0, s5_lhs} - {1'b0, s5_rhs};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_v    <= v;
      s1_d    <= d;
      s1_h    <= h;
      s1_g    <= g;
      s1_zero <= (v == 16'd0) || (d == 16'd0);

      s2_v2   <= s1_v * s1_v;
      s2_gd   <= s1_g * s1_d;
      s2_dd   <= s1_d * s1_d;
      s2_gh   <= $signed({1'b0, s1_g}) * s1_h;
      s2_d    <= s1_d;
      s2_g    <= s1_g;
      s2_h    <= s1_h;
      s2_zero <= s1_zero;

      s3_p    <= $signed({7'b0, s2_v2}) + $signed({s2_gh[32], s2_gh, 5'b0});
      s3_gg   <= s2_gd * s2_gd;
      s3_gdd  <= s2_g * s2_dd;
      s3_hv2  <= s2_h * $signed({1'b0, s2_v2});
      s3_v2   <= s2_v2;
      s3_d    <= s2_d;
      s3_zero <= s2_zero;

      s4_pneg   <= s3_p[38];
      s4_lhs_lo <= s3_v2 * s3_p[31:0];
      s4_lhs_hi <= s3_v2 * s3_p[37:32];
      s4_rhs    <= {s3_gg, 8'b0};
      s4_yq     <= $signed({2'b0, s3_gdd, 4'b0}) - $signed({{4{s3_hv2[48]}}, s3_hv2, 1'b0});
      s4_v2     <= s3_v2;
      s4_d      <= s3_d;
      s4_zero   <= s3_zero;

      s5_pneg <= s4_pneg;
      s5_lhs  <= {8'b0, s4_lhs_lo} + {2'b0, s4_lhs_hi, 32'b0};
      s5_rhs  <= s4_rhs;
      s5_yq   <= s4_yq;
      s5_v2   <= s4_v2;
      s5_d    <= s4_d;
      s5_zero <= s4_zero;

      radicand <= diff[71:0];
      side.d   <= s5_d;
      side.v2  <= s5_v2;
      side.yq  <= s5_yq;
      if (s5_zero) begin
        side.status <= dflps_pkg::ST_ZERO;
      end else if (s5_pneg || diff[72]) begin
        side.status <= dflps_pkg::ST_UNREACH;
      end else begin
        side.status <= dflps_pkg::ST_SOLVED;
      end
    end
  end

  assign out_valid = vld[5];

endmodule

// File: src/dflps_sqrt.sv
// Pipelined integer square root, one root bit per stage, sideband carried alongside.
// Depends on dflps_pkg.
module dflps_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [dflps_pkg::RAD_W-1:0]   radicand,
  input  dflps_pkg::side_t              in_side,
  output logic                          out_valid,
  output logic [dflps_pkg::ROOT_W-1:0]  root,
  output dflps_pkg::side_t              out_side
);

  localparam int N  = dflps_pkg::SQRT_STEPS;
  localparam int RW = dflps_pkg::ROOT_W;
  localparam int MW = dflps_pkg::REM_W;
  localparam int AW = dflps_pkg::RAD_W;

  logic [N:0]      vld;
  logic [MW-1:0]   rem  [0:N];
  logic [RW-1:0]   rt   [0:N];
  logic [AW-1:0]   rest [0:N];
  dflps_pkg::side_t sd  [0:N];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign rest[0] = radicand;
  assign sd[0]   = in_side;

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [MW-1:0] cur, trial;
    logic          ge;

    assign cur   = {rem[k][MW-3:0], rest[k][AW-1:AW-2]};
    assign trial = {2'b0, rt[k], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? cur - trial : cur;
        rt[k+1]   <= {rt[k][RW-2:0], ge};
        rest[k+1] <= {rest[k][AW-3:0], 2'b0};
        sd[k+1]   <= sd[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign root      = rt[N];
  assign out_side  = sd[N];

endmodule

// File: src/dflps_cordic.sv
// Denominator product, normalizing shifter, vectoring CORDIC arctangent and rounding.
// Depends on dflps_pkg.
module dflps_cordic #(
  parameter int CORDIC_ITERATIONS = dflps_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [dflps_pkg::ROOT_W-1:0]  root,
  input  dflps_pkg::side_t              in_side,
  output logic                          out_valid,
  output logic signed [15:0]            pitch,
  output logic [1:0]                    status
);

  localparam int NIT = (CORDIC_ITERATIONS > dflps_pkg::ATAN_LEN) ?
                       dflps_pkg::ATAN_LEN : CORDIC_ITERATIONS;
  localparam int NS  = 6;

  logic [2:0] cvld;

  logic [36:0] c0_sum;
  logic [52:0] c0_ymag;
  logic [15:0] c0_d;
  logic        c0_yneg;
  logic [1:0]  c0_status;

  logic [52:0] c1_x, c1_y;
  logic        c1_yneg;
  logic [1:0]  c1_status;

  logic [53:0] yabs;

  assign yabs = in_side.yq[53] ? -in_side.yq : in_side.yq;

  logic [NS:0]  nvld;
  logic [63:0]  nx [0:NS];
  logic [63:0]  ny [0:NS];
  logic [63:0]  nm [0:NS];
  logic [NS:0]  nneg;
  logic [1:0]   nst [0:NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cvld <= '0;
    end else if (en) begin
      cvld <= {cvld[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_sum    <= {5'b0, in_side.v2} + {1'b0, root};
      c0_ymag   <= yabs[52:0];
      c0_d      <= in_side.d;
      c0_yneg   <= in_side.yq[53];
      c0_status <= in_side.status;

      c1_x      <= c0_d * c0_sum;
      c1_y      <= c0_ymag;
      c1_yneg   <= c0_yneg;
      c1_status <= c0_status;

      nx[0]   <= {11'b0, c1_x};
      ny[0]   <= {11'b0, c1_y};
      nm[0]   <= (c1_x > c1_y) ? {11'b0, c1_x} : {11'b0, c1_y};
      nneg[0] <= c1_yneg;
      nst[0]  <= c1_status;
    end
  end

  assign nvld[0] = cvld[2];

  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic up;

    assign up = (nm[j][63 -: SH] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        nvld[j+1] <= 1'b0;
      end else if (en) begin
        nvld[j+1] <= nvld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx[j+1]   <= up ? nx[j] << SH : nx[j];
        ny[j+1]   <= up ? ny[j] << SH : ny[j];
        nm[j+1]   <= up ? nm[j] << SH : nm[j];
        nneg[j+1] <= nneg[j];
        nst[j+1]  <= nst[j];
      end
    end
  end

  logic [NIT:0]       kvld;
  logic signed [31:0] cx [0:NIT];
  logic signed [31:0] cy [0:NIT];
  logic signed [31:0] cz [0:NIT];
  logic [NIT:0]       kneg;
  logic [1:0]         kst [0:NIT];

  // MSB of the larger operand lands on bit 28
  assign kvld[0] = nvld[NS];
  assign cx[0]   = $signed({3'b0, nx[NS][63:35]});
  assign cy[0]   = $signed({3'b0, ny[NS][63:35]});
  assign cz[0]   = '0;
  assign kneg[0] = nneg[NS];
  assign kst[0]  = nst[NS];

  for (genvar i = 0; i < NIT; i++) begin : g_iter
    logic signed [31:0] xs, ys, at;

    assign xs = cx[i] >>> i;
    assign ys = cy[i] >>> i;
    assign at = dflps_pkg::atan_entry(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        kvld[i+1] <= 1'b0;
      end else if (en) begin
        kvld[i+1] <= kvld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy[i][31]) begin
          cx[i+1] <= cx[i] + ys;
          cy[i+1] <= cy[i] - xs;
          cz[i+1] <= cz[i] + at;
        end else begin
          cx[i+1] <= cx[i] - ys;
          cy[i+1] <= cy[i] + xs;
          cz[i+1] <= cz[i] - at;
        end
        kneg[i+1] <= kneg[i];
        kst[i+1]  <= kst[i];
      end
    end
  end

  logic signed [32:0] zext, zmag, q;
  logic [32:0]        rnd;
  logic               qneg;

  assign zext = {cz[NIT][31], cz[NIT]};
  assign zmag = zext[32] ? -zext : zext;
  assign rnd  = ($unsigned(zmag) + 33'd32768) >> 16;
  assign qneg = zext[32] ^ kneg[NIT];
  assign q    = qneg ? -$signed(rnd) : $signed(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= kvld[NIT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= kst[NIT];
      pitch  <= (kst[NIT] == dflps_pkg::ST_SOLVED) ? q[15:0] : 16'sd0;
    end
  end

endmodule

// File: src/drag_free_launch_pitch_solver_core.sv
// Top level of the drag-free launch pitch solver: APB gravity register and pipeline.
// Depends on dflps_pkg, dflps_front, dflps_sqrt, dflps_cordic.
//
// Accepts one target word per cycle while the pipeline advances and returns one pitch
// word per target, in order, through six front stages of products and the discriminant,
// 36 square-root stages of one root bit each, three stages for the denominator product,
// six normalizing shift stages, one stage per CORDIC iteration (iterations above 24
// count as 24) and one rounding stage.
// The whole pipeline advances while the output register is empty or being taken and
// holds as one when a result waits. Gravity is sampled as a target enters.
module drag_free_launch_pitch_solver_core #(
  parameter int CORDIC_ITERATIONS = dflps_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        launch_speed,
  input  logic [15:0]        target_distance,
  input  logic signed [15:0] target_height,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pitch_angle,
  output logic [1:0]         solve_status
);

  logic [15:0] gravity;
  logic        en;

  logic                         f_valid;
  logic [dflps_pkg::RAD_W-1:0]  f_rad;
  dflps_pkg::side_t             f_side;
  logic                         q_valid;
  logic [dflps_pkg::ROOT_W-1:0] q_root;
  dflps_pkg::side_t             q_side;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == dflps_pkg::REG_GRAVITY) ? {16'b0, gravity} : 32'b0;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= dflps_pkg::GRAVITY_RESET;
    end else if (psel && penable && pwrite && paddr[2] == dflps_pkg::REG_GRAVITY) begin
      gravity <= pwdata[15:0];
    end
  end

  dflps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .v         (launch_speed),
    .d         (target_distance),
    .h         (target_height),
    .g         (gravity),
    .out_valid (f_valid),
    .radicand  (f_rad),
    .side      (f_side)
  );

  dflps_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .radicand  (f_rad),
    .in_side   (f_side),
    .out_valid (q_valid),
    .root      (q_root),
    .out_side  (q_side)
  );

  dflps_cordic #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .root      (q_root),
    .in_side   (q_side),
    .out_valid (out_valid),
    .pitch     (pitch_angle),
    .status    (solve_status)
  );

endmodule

// File: src/dflps_checker.sv
// Port-level checks for the launch pitch solver, bound to the top level.
// Depends on dflps_pkg and drag_free_launch_pitch_solver_core.
module dflps_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] pitch_angle,
  input logic [1:0]         solve_status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pitch_angle) && $stable(solve_status))
    else $error("result word changed while stalled");

  a_zero_pitch: assert property (@(posedge clk) disable iff (rst)
    out_valid && solve_status != dflps_pkg::ST_SOLVED |-> pitch_angle == 16'sd0)
    else $error("nonzero pitch on failed solve");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> solve_status == dflps_pkg::ST_SOLVED || solve_status == dflps_pkg::ST_UNREACH
                  || solve_status == dflps_pkg::ST_ZERO)
    else $error("undefined status code");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with output empty");

endmodule

bind drag_free_launch_pitch_solver_core dflps_checker u_chk (.*);

// File: bench/drag_free_launch_pitch_solver_core_chk.sv
// Checker for the launch pitch solver: tracks gravity, predicts each pitch word
// and compares results in order. Depends on dflps_pkg.
module drag_free_launch_pitch_solver_core_chk #(
  parameter int CORDIC_ITERATIONS = dflps_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [15:0]        launch_speed,
  input  logic [15:0]        target_distance,
  input  logic signed [15:0] target_height,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] pitch_angle,
  input  logic [1:0]         solve_status,
  input  logic               check_done,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] pitch;
    logic [1:0]         status;
  } pitch_word_t;

  pitch_word_t expected_pitches[$];
  logic [15:0] gravity_q;
  logic        done_seen;

  initial begin
    errors = 0;
    done_seen = 1'b0;
  end

  assign pending = expected_pitches.size();

  task automatic report(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic pitch_word_t solve_pitch(input logic [15:0] v, input logic [15:0] d,
                                              input logic signed [15:0] h,
                                              input logic [15:0] g);
    pitch_word_t r;
    longint v2, p, gd16, s, xq, yq, x, y, z, q, xs, ys;
    longint unsigned ax, ay, m;
    logic [127:0] lhs, rhs, rad, c;
    int iters;
    r.pitch = '0;
    r.status = dflps_pkg::ST_SOLVED;
    if (v == 0 || d == 0) begin
      r.status = dflps_pkg::ST_ZERO;
      return r;
    end
    v2 = longint'(v) * longint'(v);
    p = v2 + 32 * longint'(g) * longint'(h);
    gd16 = 16 * longint'(g) * longint'(d);
    if (p < 0) begin
      r.status = dflps_pkg::ST_UNREACH;
      return r;
    end
    lhs = 128'(v2) * 128'(p);
    rhs = 128'(gd16) * 128'(gd16);
    if (lhs < rhs) begin
      r.status = dflps_pkg::ST_UNREACH;
      return r;
    end
    rad = lhs - rhs;
    s = 0;
    for (int b = 40; b >= 0; b--) begin
      c = 128'(s) | (128'(1) << b);
      if (!(rad < c * c)) s = longint'(c);
    end
    xq = longint'(d) * (v2 + s);
    yq = gd16 * longint'(d) - 2 * longint'(h) * v2;
    ax = xq;
    ay = (yq < 0) ? -yq : yq;
    m = (ax > ay) ? ax : ay;
    while (m >= (64'd1 << 29)) begin
      ax >>= 1; ay >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 28)) begin
      ax <<= 1; ay <<= 1; m <<= 1;
    end
    x = ax;
    y = ay;
    z = 0;
    iters = (CORDIC_ITERATIONS > dflps_pkg::ATAN_LEN) ? dflps_pkg::ATAN_LEN
                                                      : CORDIC_ITERATIONS;
    for (int i = 0; i < iters; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(dflps_pkg::atan_entry(i));
      end else begin
        x -= ys; y += xs; z -= longint'(dflps_pkg::atan_entry(i));
      end
    end
    q = (z >= 0) ? ((z + 32768) >>> 16) : -((-z + 32768) >>> 16);
    if (yq < 0) q = -q;
    r.pitch = q[15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    pitch_word_t e;
    if (rst) begin
      gravity_q <= dflps_pkg::GRAVITY_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == dflps_pkg::REG_GRAVITY)
        gravity_q <= pwdata[15:0];
      if (in_valid && in_ready)
        expected_pitches.push_back(solve_pitch(launch_speed, target_distance,
                                               target_height, gravity_q));
      if (out_valid && out_ready) begin
        if (expected_pitches.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          e = expected_pitches.pop_front();
          if (solve_status !== e.status)
            report($sformatf("status got %0d exp %0d", solve_status, e.status));
          if (pitch_angle !== e.pitch)
            report($sformatf("pitch got %0d exp %0d", pitch_angle, e.pitch));
        end
      end
      if (check_done && !done_seen) begin
        done_seen <= 1'b1;
        if (expected_pitches.size() != 0)
          report($sformatf("%0d words never arrived", expected_pitches.size()));
      end
    end
  end
endmodule

// File: bench/drag_free_launch_pitch_solver_core_tb.sv
// Top of the launch pitch solver bench: clock, reset, APB gravity writes, target
// stimulus and verdict. Depends on dflps_pkg, the core and its checker.
module drag_free_launch_pitch_solver_core_tb;

  localparam int LIMIT = 2000000;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [15:0] launch_speed, target_distance;
  logic signed [15:0] target_height;
  logic signed [15:0] pitch_angle;
  logic [1:0] solve_status;
  logic check_done, quiet;
  int errors, pending, cycles;

  drag_free_launch_pitch_solver_core DUT (.*);
  drag_free_launch_pitch_solver_core_chk CHK (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst || quiet) begin
      out_ready <= 1'b1;
    end else if (out_ready && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
      out_ready <= 1'b1;
    end
  end

  task automatic write_gravity(input logic [15:0] g);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {dflps_pkg::REG_GRAVITY, 2'b00}; pwdata <= {16'd0, g};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send_target(input logic [15:0] v, input logic [15:0] d,
                             input logic signed [15:0] h);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    launch_speed <= v; target_distance <= d; target_height <= h;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic random_target;
    logic [15:0] v, d;
    logic signed [15:0] h;
    v = $urandom;
    d = $urandom;
    h = $urandom;
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        v = $urandom_range(4000, 65535);
        d = $urandom_range(1, 1 + v / 8);
        h = $signed(16'($urandom_range(0, 2 * d))) - $signed(16'(d));
      end
      2: begin
        v = $urandom_range(1000, 65535);
        d = $urandom_range(1, 4096);
        h = $urandom_range(0, 1) ? $signed(16'($urandom_range(0, 4096)))
                                 : -$signed(16'($urandom_range(0, 4096)));
      end
      default: begin
        v = $urandom_range(0, 3) == 0 ? 16'd0 : v;
        d = $urandom_range(0, 3) == 0 ? 16'd0 : d;
      end
    endcase
    send_target(v, d, h);
  endtask

  initial begin
    logic [15:0] gravities [5];
    gravities = '{16'd2511, 16'd0, 16'd65535, 16'd1, 16'd0};
    gravities[4] = $urandom;
    cycles = 0;
    rst = 1'b1; quiet = 1'b0; check_done = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid = 1'b0; launch_speed = '0; target_distance = '0; target_height = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_target(16'd0, 16'd1000, 16'sd0);
    send_target(16'd1000, 16'd0, 16'sd0);
    send_target(16'd0, 16'd0, -16'sd32768);
    send_target(16'd65535, 16'd65535, 16'sd32767);
    send_target(16'd65535, 16'd65535, -16'sd32768);
    send_target(16'd65535, 16'd1, 16'sd0);
    send_target(16'd65535, 16'd1, 16'sd32767);
    send_target(16'd65535, 16'd1, -16'sd32768);
    send_target(16'd1, 16'd65535, 16'sd0);
    send_target(16'd1, 16'd1, -16'sd32768);
    send_target(16'd10240, 16'd2560, 16'sd0);
    send_target(16'd10240, 16'd2560, 16'sd1280);
    send_target(16'd10240, 16'd2560, -16'sd1280);
    send_target(16'd20480, 16'd65535, 16'sd0);
    send_target(16'd32768, 16'd12800, 16'sd25600);
    send_target(16'd5000, 16'd100, 16'sd32767);
    drain();
    write_gravity(16'd0);
    send_target(16'd10240, 16'd2560, 16'sd1280);
    send_target(16'd10240, 16'd2560, -16'sd1280);
    send_target(16'd1, 16'd65535, 16'sd0);
    send_target(16'd65535, 16'd1, 16'sd32767);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_gravity(gravities[ph]);
      quiet = (ph == 4);
      for (int n = 0; n < 180; n++) begin
        random_target();
        if (ph == 1 && n == 90) begin
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
      end
      drain();
    end

    check_done = 1'b1;
    repeat (3) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: sim.f
src/dflps_pkg.sv
src/dflps_front.sv
src/dflps_sqrt.sv
src/dflps_cordic.sv
src/drag_free_launch_pitch_solver_core.sv
src/dflps_checker.sv
bench/drag_free_launch_pitch_solver_core_chk.sv
bench/drag_free_launch_pitch_solver_core_tb.sv
